@@ src/affine_matrix_stack_4x4_assert.svh @@
// Assertion macros for the checker module of the matrix stack.
`ifndef AFFINE_MATRIX_STACK_4X4_ASSERT_SVH
`define AFFINE_MATRIX_STACK_4X4_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define AMSTK_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define AMSTK_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/amstk_pkg.sv @@
// Types, codes and constants shared by the matrix stack modules.
package amstk_pkg;

   localparam int NUM_WORDS = 16;
   localparam int IDX_W     = 4;
   localparam int AMT_W     = 32;
   localparam int OUT_W     = 32;
   localparam int CHUNK_W   = 32;

   localparam logic [IDX_W-1:0] LAST_IDX = 4'd15;

   // Column numbers within a 4x4 column-major matrix
   localparam logic [1:0] COL_X = 2'd0;
   localparam logic [1:0] COL_Y = 2'd1;
   localparam logic [1:0] COL_Z = 2'd2;
   localparam logic [1:0] COL_W = 2'd3;

   typedef enum logic [2:0] {
      ACT_PUSH_TRANSLATE = 3'd0,
      ACT_PUSH_SCALE     = 3'd1,
      ACT_POP            = 3'd2,
      ACT_SET_IDENTITY   = 3'd3,
      ACT_SCALE          = 3'd4,
      ACT_READ_TOP       = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_OVERFLOW  = 2'd1,
      STAT_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL_LOAD,
      ST_MUL_RUN,
      ST_WRITE,
      ST_EMIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } mul_ctrl_type;

   typedef struct packed {
      logic             rd_en;
      logic             wr_en;
      logic [IDX_W-1:0] rd_idx;
      logic [IDX_W-1:0] wr_idx;
   } store_ctrl_type;

   // True for the four words on the main diagonal
   function automatic logic on_diagonal(input logic [IDX_W-1:0] idx);
      return idx inside {4'd0, 4'd5, 4'd10, 4'd15};
   endfunction

endpackage

@@ src/affine_matrix_stack_4x4.sv @@
// Top level of the 4x4 affine matrix stack: sequencer, level tracking and result port.
//
// Stack of STACK_DEPTH 4x4 column-major matrices in signed fixed point with
// FRAC_BITS fraction bits; the root level is identity after reset. An item is
// taken when start is high and busy is low; busy then stays high until the
// item's work is done. Results come out on the rsp_ ports for exactly one
// cycle each, flagged by rsp_strobe, and cannot be held off: the receiver
// must take every strobed result. Every action gives one result with
// rsp_last set, except read-top, which gives sixteen results on consecutive
// cycles, word index 0 to 15, the last one flagged. All words pass through a
// single-port-per-direction word memory one at a time, and all products go
// through one shared multiplier that works on the word in NCHUNK =
// ceil(WORD_WIDTH/32) chunks of 32 bits, top chunk first. Pop, overflowing
// push, underflowing pop and unused codes go straight to the result;
// set-identity writes the sixteen words; read-top reads and hands them out;
// push-translate, push-scale and scale read each word, multiply it where
// needed and write it. The result of a single-result item, and the last word
// of a read-top, appears in the first cycle with busy low. No clearing pass
// is needed after reset.
module affine_matrix_stack_4x4
   import amstk_pkg::*;
#(
   parameter int STACK_DEPTH = 16,
   parameter int WORD_WIDTH  = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [2:0]              req_action,
   input  logic signed [AMT_W-1:0] req_x_amount,
   input  logic signed [AMT_W-1:0] req_y_amount,
   input  logic signed [AMT_W-1:0] req_z_amount,
   output logic                    rsp_strobe,
   output logic [3:0]              rsp_level,
   output logic signed [OUT_W-1:0] rsp_word_value,
   output logic [IDX_W-1:0]        rsp_word_index,
   output logic                    rsp_last,
   output logic [1:0]              rsp_status
);

   localparam int LVL_W = $clog2(STACK_DEPTH);

   localparam logic [LVL_W-1:0] TOP_MAX = LVL_W'(STACK_DEPTH - 1);

   localparam logic [WORD_WIDTH-1:0] WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam logic [WORD_WIDTH-1:0] WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
   localparam logic [WORD_WIDTH-1:0] ONE_WORD = (FRAC_BITS >= WORD_WIDTH - 1) ? WORD_MAX :
                                              ({{(WORD_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS);

   // Saturating add in the word range
   function automatic logic [WORD_WIDTH-1:0] sat_add(input logic [WORD_WIDTH-1:0] a,
                                                     input logic [WORD_WIDTH-1:0] b);
      logic [WORD_WIDTH:0] s;
      s = {a[WORD_WIDTH-1], a} + {b[WORD_WIDTH-1], b};
      if (s[WORD_WIDTH] != s[WORD_WIDTH-1]) begin
         return s[WORD_WIDTH] ? WORD_MIN : WORD_MAX;
      end
      return s[WORD_WIDTH-1:0];
   endfunction

   // Sign-extend or truncate a stored word to the result width
   function automatic logic [OUT_W-1:0] word_out(input logic [WORD_WIDTH-1:0] w);
      logic [WORD_WIDTH+OUT_W-1:0] e;
      e = {{OUT_W{w[WORD_WIDTH-1]}}, w};
      return e[OUT_W-1:0];
   endfunction

   // Low four bits of a level
   function automatic logic [3:0] level_out(input logic [LVL_W-1:0] lvl);
      logic [LVL_W+3:0] e;
      e = {4'b0, lvl};
      return e[3:0];
   endfunction

   // Sequencer state
   state_type                state_ff, state_in;
   action_type               act_ff, act_in;
   logic [LVL_W-1:0]         top_ff, top_in;
   logic [LVL_W-1:0]         dst_ff, dst_in;
   logic [IDX_W-1:0]         j_ff, j_in;

   // Item payload and row accumulator
   logic signed [AMT_W-1:0]  x_ff, x_in;
   logic signed [AMT_W-1:0]  y_ff, y_in;
   logic signed [AMT_W-1:0]  z_ff, z_in;
   logic [WORD_WIDTH-1:0]    tacc_ff, tacc_in;

   // Result register
   logic                     rsp_strobe_ff, rsp_strobe_in;
   logic [3:0]               rsp_level_ff, rsp_level_in;
   logic [OUT_W-1:0]         rsp_word_ff, rsp_word_in;
   logic [IDX_W-1:0]         rsp_index_ff, rsp_index_in;
   logic                     rsp_last_ff, rsp_last_in;
   status_type               rsp_status_ff, rsp_status_in;

   // Datapath hook-up
   store_ctrl_type           store_ctrl;
   logic [WORD_WIDTH-1:0]    wr_data;
   logic signed [WORD_WIDTH-1:0] word_q;
   mul_ctrl_type             mul_ctrl;
   logic signed [AMT_W-1:0]  mul_b;
   logic                     mul_done;
   logic signed [WORD_WIDTH-1:0] mul_product;

   // Step order: rows outer, columns inner, so a row's translate sum is
   // ready before its fourth column. Read-top walks the words in order.
   logic [1:0]               col;
   logic [IDX_W-1:0]         idx_cur;
   logic                     needs_mul;

   assign col     = j_ff[1:0];
   assign idx_cur = (act_ff == ACT_READ_TOP) ? j_ff : {j_ff[1:0], j_ff[3:2]};

   always_comb begin
      case (act_ff)
         ACT_PUSH_TRANSLATE, ACT_PUSH_SCALE: begin
            needs_mul = (col == COL_X) || (col == COL_Y);
         end
         ACT_SCALE: begin
            needs_mul = (col != COL_W);
         end
         default: begin
            needs_mul = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (col)
         COL_X:   mul_b = x_ff;
         COL_Y:   mul_b = y_ff;
         default: mul_b = z_ff;
      endcase
   end

   amstk_store #(
      .STACK_DEPTH (STACK_DEPTH),
      .WORD_W      (WORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (store_ctrl),
      .rd_lvl  (top_ff),
      .wr_lvl  (dst_ff),
      .wr_data (wr_data),
      .rd_word (word_q)
   );

   amstk_mul #(
      .WORD_W    (WORD_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_mul (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (mul_ctrl),
      .word_a   (word_q),
      .amount_b (mul_b),
      .done     (mul_done),
      .product  (mul_product)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         top_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         top_ff        <= top_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      dst_ff        <= dst_in;
      j_ff          <= j_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      z_ff          <= z_in;
      tacc_ff       <= tacc_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      top_in        = top_ff;
      dst_in        = dst_ff;
      j_in          = j_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      tacc_in       = tacc_ff;
      rsp_strobe_in = 1'b0;
      rsp_level_in  = rsp_level_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      store_ctrl        = '0;
      store_ctrl.rd_idx = idx_cur;
      store_ctrl.wr_idx = idx_cur;
      wr_data       = '0;
      mul_ctrl      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               act_in = action_type'(req_action);
               x_in   = req_x_amount;
               y_in   = req_y_amount;
               z_in   = req_z_amount;
               j_in   = '0;
               dst_in = top_ff;
               case (action_type'(req_action))
                  ACT_PUSH_TRANSLATE, ACT_PUSH_SCALE: begin
                     // A full stack skips the copy and reports overflow
                     if (top_ff == TOP_MAX) begin
                        state_in = ST_DONE;
                     end else begin
                        dst_in   = top_ff + 1'b1;
                        state_in = ST_READ;
                     end
                  end
                  ACT_SET_IDENTITY: begin
                     state_in = ST_WRITE;
                  end
                  ACT_SCALE, ACT_READ_TOP: begin
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_READ: begin
            store_ctrl.rd_en = 1'b1;
            if (act_ff == ACT_READ_TOP) begin
               state_in = ST_EMIT;
            end else if (needs_mul) begin
               state_in = ST_MUL_LOAD;
            end else begin
               state_in = ST_WRITE;
            end
         end

         ST_MUL_LOAD: begin
            mul_ctrl.load = 1'b1;
            state_in      = ST_MUL_RUN;
         end

         ST_MUL_RUN: begin
            mul_ctrl.step = 1'b1;
            if (mul_done) begin
               state_in = ST_WRITE;
            end
         end

         ST_WRITE: begin
            store_ctrl.wr_en = 1'b1;
            case (act_ff)
               ACT_SET_IDENTITY: begin
                  wr_data = on_diagonal(idx_cur) ? ONE_WORD : '0;
               end
               ACT_PUSH_TRANSLATE: begin
                  // Copy the first three columns, fold x*col0 + y*col1 into col3
                  case (col)
                     COL_X: begin
                        wr_data = word_q;
                        tacc_in = mul_product;
                     end
                     COL_Y: begin
                        wr_data = word_q;
                        tacc_in = sat_add(tacc_ff, mul_product);
                     end
                     COL_Z: begin
                        wr_data = word_q;
                     end
                     default: begin
                        wr_data = sat_add(word_q, tacc_ff);
                     end
                  endcase
               end
               ACT_PUSH_SCALE: begin
                  case (col)
                     COL_X, COL_Y: wr_data = mul_product;
                     COL_Z:        wr_data = '0;
                     default:      wr_data = word_q;
                  endcase
               end
               default: begin
                  wr_data = (col == COL_W) ? word_q : mul_product;
               end
            endcase
            j_in = j_ff + 1'b1;
            if (j_ff == LAST_IDX) begin
               state_in = ST_DONE;
            end else if (act_ff == ACT_SET_IDENTITY) begin
               state_in = ST_WRITE;
            end else begin
               state_in = ST_READ;
            end
         end

         ST_EMIT: begin
            // Hand out this word and fetch the next in the same cycle
            rsp_strobe_in     = 1'b1;
            rsp_level_in      = level_out(top_ff);
            rsp_word_in       = word_out(word_q);
            rsp_index_in      = j_ff;
            rsp_last_in       = (j_ff == LAST_IDX);
            rsp_status_in     = STAT_OK;
            store_ctrl.rd_en  = (j_ff != LAST_IDX);
            store_ctrl.rd_idx = j_ff + 1'b1;
            j_in              = j_ff + 1'b1;
            if (j_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end

         ST_DONE: begin
            rsp_strobe_in = 1'b1;
            rsp_word_in   = '0;
            rsp_index_in  = '0;
            rsp_last_in   = 1'b1;
            rsp_status_in = STAT_OK;
            rsp_level_in  = level_out(top_ff);
            case (act_ff)
               ACT_PUSH_TRANSLATE, ACT_PUSH_SCALE: begin
                  if (top_ff == TOP_MAX) begin
                     rsp_status_in = STAT_OVERFLOW;
                  end else begin
                     top_in = top_ff + 1'b1;
                  end
               end
               ACT_POP: begin
                  if (top_ff == '0) begin
                     rsp_status_in = STAT_UNDERFLOW;
                  end else begin
                     top_in       = top_ff - 1'b1;
                     rsp_level_in = level_out(top_ff - 1'b1);
                  end
               end
               default: begin
                  rsp_status_in = STAT_OK;
               end
            endcase
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_level      = rsp_level_ff;
   assign rsp_word_value = rsp_word_ff;
   assign rsp_word_index = rsp_index_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

@@ src/amstk_mul.sv @@
// Iterative fixed-point multiplier: word times amount, shift and saturate.
module amstk_mul
   import amstk_pkg::*;
#(
   parameter int WORD_W    = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mul_ctrl_type             ctrl,
   input  logic signed [WORD_W-1:0] word_a,
   input  logic signed [AMT_W-1:0]  amount_b,
   output logic                     done,
   output logic signed [WORD_W-1:0] product
);

   localparam int NCHUNK = (WORD_W + CHUNK_W - 1) / CHUNK_W;
   localparam int EXT_W  = NCHUNK * CHUNK_W;
   localparam int PW     = WORD_W + AMT_W;
   localparam int CNT_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

   localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   logic signed [EXT_W-1:0]   a_ext;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [CNT_W-1:0]          sel_idx;
   logic signed [CHUNK_W:0]   op_a;
   logic signed [CHUNK_W+AMT_W:0] prod;
   logic signed [PW-1:0]      prod_w;
   logic signed [PW-1:0]      acc_ff, acc_in;
   logic signed [PW-1:0]      q;
   logic [PW-WORD_W:0]        q_hi;

   assign a_ext   = EXT_W'(word_a);
   assign sel_idx = cnt_ff - 1'b1;

   // Top chunk carries the sign, lower chunks are unsigned
   always_comb begin
      if (ctrl.load) begin
         op_a = {a_ext[EXT_W-1], a_ext[EXT_W-1 -: CHUNK_W]};
      end else begin
         op_a = {1'b0, a_ext[sel_idx*CHUNK_W +: CHUNK_W]};
      end
   end

   assign prod   = op_a * amount_b;
   assign prod_w = PW'(prod);

   // Horner accumulation from the top chunk down
   always_comb begin
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      if (ctrl.load) begin
         acc_in = prod_w;
         cnt_in = CNT_W'(NCHUNK - 1);
      end else if (ctrl.step && (cnt_ff != '0)) begin
         acc_in = (acc_ff <<< CHUNK_W) + prod_w;
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign done = (cnt_ff == '0);

   // Arithmetic shift rounds toward minus infinity, then clamp to the word range
   assign q    = acc_ff >>> FRAC_BITS;
   assign q_hi = q[PW-1:WORD_W-1];

   always_comb begin
      if ((&q_hi) || !(|q_hi)) begin
         product = q[WORD_W-1:0];
      end else if (q[PW-1]) begin
         product = WORD_MIN;
      end else begin
         product = WORD_MAX;
      end
   end

endmodule

@@ src/amstk_store.sv @@
// Matrix word memory with a reset-time identity root level.
module amstk_store
   import amstk_pkg::*;
#(
   parameter int STACK_DEPTH = 16,
   parameter int WORD_W      = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  store_ctrl_type                   ctrl,
   input  logic [$clog2(STACK_DEPTH)-1:0]   rd_lvl,
   input  logic [$clog2(STACK_DEPTH)-1:0]   wr_lvl,
   input  logic [WORD_W-1:0]                wr_data,
   output logic signed [WORD_W-1:0]         rd_word
);

   localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic [WORD_W-1:0] ONE_WORD = (FRAC_BITS >= WORD_W - 1) ? WORD_MAX :
                                            ({{(WORD_W-1){1'b0}}, 1'b1} << FRAC_BITS);

   logic [WORD_W-1:0]    mem_ff [STACK_DEPTH*NUM_WORDS];
   logic [WORD_W-1:0]    rd_data_ff;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic                 rd_ident_ff;
   logic [NUM_WORDS-1:0] root_valid_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem_ff[{wr_lvl, ctrl.wr_idx}] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem_ff[{rd_lvl, ctrl.rd_idx}];
         rd_idx_ff  <= ctrl.rd_idx;
      end
   end

   // Root words not yet written read as identity
   always_ff @(posedge clock) begin
      if (reset) begin
         root_valid_ff <= '0;
         rd_ident_ff   <= 1'b0;
      end else begin
         if (ctrl.wr_en && (wr_lvl == '0)) begin
            root_valid_ff[ctrl.wr_idx] <= 1'b1;
         end
         if (ctrl.rd_en) begin
            rd_ident_ff <= (rd_lvl == '0) && !root_valid_ff[ctrl.rd_idx];
         end
      end
   end

   always_comb begin
      if (rd_ident_ff) begin
         rd_word = on_diagonal(rd_idx_ff) ? ONE_WORD : '0;
      end else begin
         rd_word = rd_data_ff;
      end
   end

endmodule

@@ src/amstk_port_checker.sv @@
// Port-level checker for the matrix stack, bound to the top level.
`include "affine_matrix_stack_4x4_assert.svh"

module amstk_port_checker
   import amstk_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic                    rsp_strobe,
   input logic signed [OUT_W-1:0] rsp_word_value,
   input logic [IDX_W-1:0]        rsp_word_index,
   input logic                    rsp_last,
   input logic [1:0]              rsp_status
);

   // An accepted item always makes the block busy in the cycle after it is taken
   `AMSTK_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy,
      "no busy after accept")

   // More results pending means the item is still in progress
   `AMSTK_ASSERT_NOW(a_stream_busy, clock, reset, rsp_strobe && !rsp_last, busy,
      "idle mid-stream")

   // A read stream runs on consecutive cycles with rising word index
   `AMSTK_ASSERT_NEXT(a_stream_next, clock, reset, rsp_strobe && !rsp_last,
      rsp_strobe && (rsp_word_index == $past(rsp_word_index) + 4'd1),
      "stream gap or index skip")

   // Error results are single, final and carry no word
   `AMSTK_ASSERT_NOW(a_error_single, clock, reset, rsp_strobe && (rsp_status != STAT_OK),
      rsp_last && (rsp_word_index == 4'd0) && (rsp_word_value == 32'sd0),
      "malformed error result")

endmodule

bind affine_matrix_stack_4x4 amstk_port_checker u_port_checker (.*);

@@ sim/affine_matrix_stack_4x4_tb.sv @@
// Self-checking testbench for the 4x4 affine matrix stack: directed, fill/drain and random runs.
module affine_matrix_stack_4x4_tb;
   import amstk_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH         = 16;
   localparam int FRAC          = 16;
   localparam int SETTLE_CYCLES = 80;   // longer than the slowest item (scale)
   localparam int REPORT_CAP    = 40;

   // Codes outside the defined actions; the block must answer them with a plain result
   localparam logic [2:0] ACT_SPARE_LO = 3'd6;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;

   localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
   localparam logic signed [31:0] AMT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] AMT_MIN = 32'sh8000_0000;
   localparam longint             WORD_HI = longint'(AMT_MAX);
   localparam longint             WORD_LO = longint'(AMT_MIN);

   // One result as the block should present it
   typedef struct packed {
      logic [3:0]         level;
      logic signed [31:0] word_value;
      logic [3:0]         word_index;
      logic               last;
      status_type         status;
   } stack_reply_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [2:0]              req_action   = '0;
   logic signed [AMT_W-1:0] req_x_amount = '0;
   logic signed [AMT_W-1:0] req_y_amount = '0;
   logic signed [AMT_W-1:0] req_z_amount = '0;
   logic                    rsp_strobe;
   logic [3:0]              rsp_level;
   logic signed [OUT_W-1:0] rsp_word_value;
   logic [IDX_W-1:0]        rsp_word_index;
   logic                    rsp_last;
   logic [1:0]              rsp_status;

   // Shadow copy of the stack: level, then column-major word
   logic signed [31:0] shadow_mats [0:DEPTH-1][0:15];
   int unsigned        top_lvl;

   stack_reply_type due_replies [$];
   int              error_count = 0;
   bit              no_idle = 1'b0;   // set to run items back to back

   always #2 clock = ~clock;

   affine_matrix_stack_4x4 #(
      .STACK_DEPTH (DEPTH),
      .WORD_WIDTH  (32),
      .FRAC_BITS   (FRAC)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_x_amount   (req_x_amount),
      .req_y_amount   (req_y_amount),
      .req_z_amount   (req_z_amount),
      .rsp_strobe     (rsp_strobe),
      .rsp_level      (rsp_level),
      .rsp_word_value (rsp_word_value),
      .rsp_word_index (rsp_word_index),
      .rsp_last       (rsp_last),
      .rsp_status     (rsp_status)
   );

   // ---------------------------------------------------------------------
   // Fixed-point arithmetic of the stack
   // ---------------------------------------------------------------------

   // Clamp an exact value into the signed 32-bit word range
   function automatic logic signed [31:0] clamp_word(input longint v);
      if (v > WORD_HI) return AMT_MAX;
      if (v < WORD_LO) return AMT_MIN;
      return v[31:0];
   endfunction

   // Product shifted right arithmetically, i.e. rounded towards minus infinity.
   // A 32x32 product always fits a longint, so no wider arithmetic is needed.
   function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      longint prod;
      prod = longint'(a) * longint'(b);
      return clamp_word(prod >>> FRAC);
   endfunction

   function automatic logic signed [31:0] fx_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      return clamp_word(longint'(a) + longint'(b));
   endfunction

   function automatic stack_reply_type make_reply(input int unsigned lvl,
                                                  input logic signed [31:0] word,
                                                  input int unsigned idx,
                                                  input logic last,
                                                  input status_type stat);
      stack_reply_type r;
      r.level      = lvl[3:0];
      r.word_value = word;
      r.word_index = idx[3:0];
      r.last       = last;
      r.status     = stat;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Predictor: apply one accepted item to the shadow stack and queue the
   // results it must produce
   // ---------------------------------------------------------------------
   task automatic apply_matrix_action(input logic [2:0] act,
                                      input logic signed [31:0] x,
                                      input logic signed [31:0] y,
                                      input logic signed [31:0] z);
      logic signed [31:0] src [0:15];
      logic signed [31:0] shift;
      for (int w = 0; w < 16; w++) src[w] = shadow_mats[top_lvl][w];
      case (act)
         ACT_PUSH_TRANSLATE, ACT_PUSH_SCALE: begin
            if (top_lvl == DEPTH - 1) begin
               // Full stack: leave everything alone and flag overflow
               due_replies.push_back(make_reply(top_lvl, '0, 0, 1'b1, STAT_OVERFLOW));
            end else begin
               if (act == ACT_PUSH_TRANSLATE) begin
                  for (int w = 0; w < 16; w++) shadow_mats[top_lvl+1][w] = src[w];
                  // Column 3 picks up x * column 0 + y * column 1
                  for (int i = 0; i < 4; i++) begin
                     shift = fx_add(fx_mul(src[i], x), fx_mul(src[i+4], y));
                     shadow_mats[top_lvl+1][i+12] = fx_add(src[i+12], shift);
                  end
               end else begin
                  // Column 2 is scaled by zero on a push-scale
                  for (int i = 0; i < 4; i++) begin
                     shadow_mats[top_lvl+1][i]    = fx_mul(src[i], x);
                     shadow_mats[top_lvl+1][i+4]  = fx_mul(src[i+4], y);
                     shadow_mats[top_lvl+1][i+8]  = fx_mul(src[i+8], '0);
                     shadow_mats[top_lvl+1][i+12] = src[i+12];
                  end
               end
               due_replies.push_back(make_reply(top_lvl, '0, 0, 1'b1, STAT_OK));
               top_lvl++;
            end
         end
         ACT_POP: begin
            if (top_lvl == 0) begin
               due_replies.push_back(make_reply(0, '0, 0, 1'b1, STAT_UNDERFLOW));
            end else begin
               top_lvl--;
               due_replies.push_back(make_reply(top_lvl, '0, 0, 1'b1, STAT_OK));
            end
         end
         ACT_SET_IDENTITY: begin
            // Diagonal words sit at every fifth index in column-major order
            for (int w = 0; w < 16; w++)
               shadow_mats[top_lvl][w] = (w % 5 == 0) ? Q_ONE : '0;
            due_replies.push_back(make_reply(top_lvl, '0, 0, 1'b1, STAT_OK));
         end
         ACT_SCALE: begin
            for (int i = 0; i < 4; i++) begin
               shadow_mats[top_lvl][i]   = fx_mul(src[i], x);
               shadow_mats[top_lvl][i+4] = fx_mul(src[i+4], y);
               shadow_mats[top_lvl][i+8] = fx_mul(src[i+8], z);
            end
            due_replies.push_back(make_reply(top_lvl, '0, 0, 1'b1, STAT_OK));
         end
         ACT_READ_TOP: begin
            for (int w = 0; w < 16; w++)
               due_replies.push_back(make_reply(top_lvl, src[w], w, w == 15, STAT_OK));
         end
         default: begin
            // Spare codes: no effect, one plain result
            due_replies.push_back(make_reply(top_lvl, '0, 0, 1'b1, STAT_OK));
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   // Draw an amount: mostly moderate Q16.16 values, some full range and extremes
   function automatic logic signed [31:0] pick_amount();
      int unsigned        r;
      logic signed [31:0] v;
      r = $urandom_range(0, 99);
      if (r < 35) begin
         v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;      // within +/-4.0
      end else if (r < 60) begin
         v = Q_ONE + $urandom_range(0, 2048) - 1024;                 // close to 1.0
      end else if (r < 80) begin
         v = $urandom;
      end else if (r < 90) begin
         case ($urandom_range(0, 4))
            0:       v = AMT_MAX;
            1:       v = AMT_MIN;
            2:       v = '0;
            3:       v = -32'sd1;
            default: v = 32'sd1;
         endcase
      end else begin
         v = 32'sd1 <<< $urandom_range(0, 30);
         if ($urandom_range(0, 1) == 1) v = -v;
      end
      return v;
   endfunction

   // Send one item: idle for a random number of cycles, present it, hold it
   // until the block takes it, then predict its results.
   task automatic issue_action(input logic [2:0] act,
                               input logic signed [31:0] x,
                               input logic signed [31:0] y,
                               input logic signed [31:0] z);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      // Drop start only when a gap follows; otherwise keep it high into the next item
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_action   <= act;
      req_x_amount <= x;
      req_y_amount <= y;
      req_z_amount <= z;
      start        <= 1'b1;
      do @(posedge clock); while (busy);
      apply_matrix_action(act, x, y, z);
   endtask

   // Root level: underflow, spare codes, identity and a plain scale
   task automatic test_root_cases();
      issue_action(ACT_POP, '0, '0, '0);
      issue_action(ACT_READ_TOP, '0, '0, '0);
      issue_action(ACT_SPARE_LO, AMT_MAX, AMT_MIN, AMT_MAX);
      issue_action(ACT_SPARE_HI, AMT_MIN, AMT_MAX, AMT_MIN);
      issue_action(ACT_SCALE, 32'sh0002_0000, 32'sh0000_8000, -Q_ONE);
      issue_action(ACT_READ_TOP, '0, '0, '0);
      issue_action(ACT_SET_IDENTITY, '0, '0, '0);
      issue_action(ACT_READ_TOP, '0, '0, '0);
   endtask

   // Extreme amounts to drive the products and sums into saturation
   task automatic test_extreme_amounts();
      issue_action(ACT_PUSH_TRANSLATE, AMT_MAX, AMT_MIN, '0);
      issue_action(ACT_READ_TOP, '0, '0, '0);
      issue_action(ACT_PUSH_TRANSLATE, AMT_MIN, AMT_MIN, AMT_MAX);
      issue_action(ACT_READ_TOP, '0, '0, '0);
      issue_action(ACT_PUSH_SCALE, AMT_MIN, AMT_MAX, -32'sd1);
      issue_action(ACT_READ_TOP, '0, '0, '0);
      issue_action(ACT_SCALE, AMT_MAX, -32'sd1, AMT_MIN);
      issue_action(ACT_READ_TOP, '0, '0, '0);
      issue_action(ACT_SCALE, 32'sd1, -Q_ONE, '0);
      issue_action(ACT_READ_TOP, '0, '0, '0);
      issue_action(ACT_POP, '0, '0, '0);
      issue_action(ACT_POP, '0, '0, '0);
      issue_action(ACT_POP, '0, '0, '0);
      issue_action(ACT_READ_TOP, '0, '0, '0);
   endtask

   // Climb to the top of the stack, try to overflow, then drain to the root and underflow
   task automatic test_fill_and_drain();
      while (top_lvl < DEPTH - 1) begin
         if ($urandom_range(0, 1) == 1)
            issue_action(ACT_PUSH_TRANSLATE, pick_amount(), pick_amount(), $urandom);
         else
            issue_action(ACT_PUSH_SCALE, pick_amount(), pick_amount(), $urandom);
      end
      issue_action(ACT_PUSH_TRANSLATE, pick_amount(), pick_amount(), $urandom);
      issue_action(ACT_PUSH_SCALE, pick_amount(), pick_amount(), $urandom);
      issue_action(ACT_READ_TOP, '0, '0, '0);
      issue_action(ACT_SCALE, pick_amount(), pick_amount(), pick_amount());
      issue_action(ACT_READ_TOP, '0, '0, '0);
      // Drain back to back to leave no idle cycles between items
      no_idle = 1'b1;
      while (top_lvl > 0) begin
         issue_action(ACT_POP, '0, '0, '0);
         if ($urandom_range(0, 3) == 0) issue_action(ACT_READ_TOP, '0, '0, '0);
      end
      issue_action(ACT_POP, '0, '0, '0);
      no_idle = 1'b0;
   endtask

   // Random walk over the stack with random content and occasional noise
   task automatic test_random_walk();
      int unsigned r;
      for (int n = 0; n < 200; n++) begin
         // Switch between idling and back-to-back stretches now and then
         if (n % 25 == 0) no_idle = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < 18)
            issue_action(ACT_PUSH_TRANSLATE, pick_amount(), pick_amount(), $urandom);
         else if (r < 32)
            issue_action(ACT_PUSH_SCALE, pick_amount(), pick_amount(), $urandom);
         else if (r < 58)
            issue_action(ACT_POP, $urandom, $urandom, $urandom);
         else if (r < 64)
            issue_action(ACT_SET_IDENTITY, $urandom, $urandom, $urandom);
         else if (r < 76)
            issue_action(ACT_SCALE, pick_amount(), pick_amount(), pick_amount());
         else if (r < 94)
            issue_action(ACT_READ_TOP, $urandom, $urandom, $urandom);
         else if (r < 97)
            issue_action(ACT_SPARE_LO, $urandom, $urandom, $urandom);
         else
            issue_action(ACT_SPARE_HI, $urandom, $urandom, $urandom);
      end
      no_idle = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      error_count++;
      if (error_count <= REPORT_CAP)
         $display("%0t: %s mismatch, expected 'h%h, actual 'h%h", $time, what, want, got);
   endtask

   // Compare every strobed result with the oldest outstanding expectation
   always @(posedge clock) begin
      stack_reply_type want;
      if (!reset && rsp_strobe) begin
         if (due_replies.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_CAP)
               $display("%0t: unexpected result, expected none, actual level %0d word 'h%h",
                        $time, rsp_level, rsp_word_value);
         end else begin
            want = due_replies.pop_front();
            if (rsp_level !== want.level)
               report_mismatch("level", 32'(want.level), 32'(rsp_level));
            if (rsp_word_value !== want.word_value)
               report_mismatch("word_value", want.word_value, rsp_word_value);
            if (rsp_word_index !== want.word_index)
               report_mismatch("word_index", 32'(want.word_index), 32'(rsp_word_index));
            if (rsp_last !== want.last)
               report_mismatch("last", 32'(want.last), 32'(rsp_last));
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(want.status), 32'(rsp_status));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequence of tests
   // ---------------------------------------------------------------------
   initial begin
      // Initialise the shadow stack: root is identity, the rest is never read unwritten
      for (int l = 0; l < DEPTH; l++)
         for (int w = 0; w < 16; w++)
            shadow_mats[l][w] = (l == 0 && w % 5 == 0) ? Q_ONE : '0;
      top_lvl = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_root_cases();
      test_extreme_amounts();
      test_fill_and_drain();
      test_random_walk();
      start <= 1'b0;

      // Drain outstanding results, then hold a while to catch stray strobes
      while (due_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("[affine_matrix_stack_4x4] OK");
      else
         $display("[affine_matrix_stack_4x4] ERROR");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #2000000;
      $display("[affine_matrix_stack_4x4] ERROR");
      $finish;
   end

endmodule

@@ affine_matrix_stack_4x4.f @@
+incdir+src
src/amstk_pkg.sv
src/amstk_mul.sv
src/amstk_store.sv
src/affine_matrix_stack_4x4.sv
src/amstk_port_checker.sv
sim/affine_matrix_stack_4x4_tb.sv
